// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising clock, off while reset is applied
`define SALC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication checked in the cycle after the antecedent, off while reset is applied
`define SALC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/salc_pkg.sv
package salc_pkg;

    // field widths
    localparam int ADDR_W     = 64;
    localparam int STAMP_W    = 32;
    localparam int CNT_W      = 32;
    localparam int SHIFT_W    = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_WAYS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS  = 2'd2;

    // configuration reset values
    localparam logic [3:0] SET_BITS_RST    = 4'd4;
    localparam logic [3:0] ACTIVE_WAYS_RST = 4'd1;
    localparam logic [5:0] BLOCK_BITS_RST  = 6'd4;

    // access kinds; the last one is ignored
    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_STORE  = 2'd1,
        ACT_MODIFY = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    // one cache line as stored in a set row
    typedef struct packed {
        logic               valid;
        logic [ADDR_W-1:0]  tag;
        logic [STAMP_W-1:0] stamp;
    } line_t;

    localparam int LINE_W = $bits(line_t);

    // controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic clear_step;
        logic accept;
        logic commit;
    } ctrl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic clear_last;
    } dp_status_t;

    // saturating add of a small increment
    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] v,
                                                 input logic [1:0] inc);
        logic [CNT_W:0] sum;
        sum = {1'b0, v} + {{(CNT_W-1){1'b0}}, inc};
        return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
    endfunction

endpackage

// File: rtl/salc_ram.sv
module salc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/salc_ctrl.sv
`include "assert_macros.svh"

module salc_ctrl
    import salc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // result slot can take a new result
    assign out_free = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
            end
            ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
            end
            ST_LOOKUP:
            begin
                cmd.commit = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // result valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // checks
    `SALC_ASSERT_NEXT(a_commit_shows, clk, rst_n, cmd.commit, out_valid_reg, "commit lost")
    `SALC_ASSERT_NEXT(a_accept_gap, clk, rst_n, cmd.accept, !cmd.accept && state_reg == ST_LOOKUP, "request overlap")
    `SALC_ASSERT(a_rose_commit, clk, rst_n, $rose(out_valid_reg) |-> $past(cmd.commit), "result without commit")
    `SALC_ASSERT(a_no_overwrite, clk, rst_n, (out_valid_reg && out_stall) |-> !cmd.commit, "held result overwritten")
    `SALC_ASSERT_NEXT(a_clear_done, clk, rst_n, state_reg == ST_CLEAR && status.clear_last, state_reg == ST_IDLE, "clear pass stuck")

endmodule

// File: rtl/salc_dp.sv
module salc_dp
    import salc_pkg::*;
#(
    parameter int MAX_SET_BITS = 8,
    parameter int MAX_WAYS     = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctrl_cmd_t             cmd,
    output dp_status_t            status,
    input  logic [ADDR_W-1:0]     address,
    input  logic [1:0]            action,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic [1:0]            hits_added,
    output logic                  missed,
    output logic                  evicted,
    output logic [CNT_W-1:0]      total_hits,
    output logic [CNT_W-1:0]      total_misses,
    output logic [CNT_W-1:0]      total_evictions
);

    localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int DEPTH = 1 << MAX_SET_BITS;
    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int ROW_W = MAX_WAYS * LINE_W;

    // configuration
    logic [3:0] set_bits_reg;
    logic [3:0] active_ways_reg;
    logic [5:0] block_bits_reg;

    // request held over the lookup
    logic [SET_W-1:0]  req_set_reg;
    logic [ADDR_W-1:0] req_tag_reg;
    action_t           req_action_reg;

    // stamp, totals and clear sweep
    logic [STAMP_W-1:0] stamp_cnt_reg;
    logic [CNT_W-1:0]   hit_cnt_reg;
    logic [CNT_W-1:0]   miss_cnt_reg;
    logic [CNT_W-1:0]   evict_cnt_reg;
    logic [SET_W-1:0]   clear_cnt_reg;

    // per-access result
    logic [1:0] hits_added_reg;
    logic       missed_reg;
    logic       evicted_reg;

    // address decode
    logic [3:0]         sb_eff;
    logic [4:0]         ways_eff;
    logic [ADDR_W-1:0]  addr_shift;
    logic [SET_W-1:0]   set_mask;
    logic [SET_W-1:0]   set_idx;
    logic [SHIFT_W-1:0] tag_shift;
    logic [ADDR_W-1:0]  tag_idx;

    // set row and lookup
    logic [ROW_W-1:0]        rd_data;
    logic [ROW_W-1:0]        wr_data;
    logic [SET_W-1:0]        wr_addr;
    logic                    wr_en;
    line_t [MAX_WAYS-1:0]    row_rd;
    line_t [MAX_WAYS-1:0]    row_wr;
    logic [MAX_WAYS-1:0]     way_active;
    logic [MAX_WAYS-1:0]     way_match;
    logic [MAX_WAYS-1:0]     way_empty;
    logic [MAX_WAYS-1:0]     lru_pick;
    logic                    hit;
    logic                    any_empty;
    logic [WAY_W-1:0]        hit_way;
    logic [WAY_W-1:0]        empty_way;
    logic [WAY_W-1:0]        lru_way;
    logic [WAY_W-1:0]        tgt_way;
    logic                    is_mod;
    logic                    is_none;
    logic [STAMP_W-1:0]      stamp_one;
    logic [STAMP_W-1:0]      stamp_two;
    logic [STAMP_W-1:0]      stamp_next;
    logic [1:0]              hits_next;
    logic                    missed_next;
    logic                    evicted_next;

    // effective configuration
    always_comb
    begin
        sb_eff = (set_bits_reg > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : set_bits_reg;
        if (active_ways_reg == 4'd0)
        begin
            ways_eff = 5'd1;
        end
        else if (5'(active_ways_reg) > 5'(MAX_WAYS))
        begin
            ways_eff = 5'(MAX_WAYS);
        end
        else
        begin
            ways_eff = 5'(active_ways_reg);
        end
    end

    // set index and tag of the incoming address
    assign addr_shift = address >> block_bits_reg;
    assign set_mask   = ~({SET_W{1'b1}} << sb_eff);
    assign set_idx    = addr_shift[SET_W-1:0] & set_mask;
    assign tag_shift  = SHIFT_W'(sb_eff) + SHIFT_W'(block_bits_reg);
    assign tag_idx    = (tag_shift >= SHIFT_W'(ADDR_W)) ? '0 : (address >> tag_shift);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg    <= SET_BITS_RST;
            active_ways_reg <= ACTIVE_WAYS_RST;
            block_bits_reg  <= BLOCK_BITS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SET_BITS:    set_bits_reg    <= cfg_data[3:0];
                CFG_ACTIVE_WAYS: active_ways_reg <= cfg_data[3:0];
                CFG_BLOCK_BITS:  block_bits_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // capture the request
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_set_reg    <= set_idx;
            req_tag_reg    <= tag_idx;
            req_action_reg <= action_t'(action);
        end
    end

    // set memory, one row holds every way
    salc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (cmd.accept),
        .raddr (set_idx),
        .rdata (rd_data)
    );

    assign row_rd = rd_data;

    // per-way compare
    always_comb
    begin
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            way_active[w] = 5'(w) < ways_eff;
            way_match[w]  = way_active[w] && row_rd[w].valid && (row_rd[w].tag == req_tag_reg);
            way_empty[w]  = way_active[w] && !row_rd[w].valid;
        end
    end

    // lowest matching way and highest empty way
    always_comb
    begin
        hit_way   = '0;
        empty_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if (way_match[w])
            begin
                hit_way = WAY_W'(w);
            end
        end
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (way_empty[w])
            begin
                empty_way = WAY_W'(w);
            end
        end
    end

    assign hit       = |way_match;
    assign any_empty = |way_empty;

    // least recently used way, every pair of stamps compared side by side;
    // a way wins when it is strictly older than the lower ways and no newer
    // than the higher ones, so ties go to the lowest index
    always_comb
    begin
        lru_pick = '0;
        lru_way  = '0;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            lru_pick[w] = way_active[w];
            for (int v = 0; v < MAX_WAYS; v++)
            begin
                if (way_active[v] && (v < w) && !(row_rd[w].stamp < row_rd[v].stamp))
                begin
                    lru_pick[w] = 1'b0;
                end
                if (way_active[v] && (v > w) && (row_rd[v].stamp < row_rd[w].stamp))
                begin
                    lru_pick[w] = 1'b0;
                end
            end
        end
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if (lru_pick[w])
            begin
                lru_way = WAY_W'(w);
            end
        end
    end

    // outcome of the access
    always_comb
    begin
        is_mod     = req_action_reg == ACT_MODIFY;
        is_none    = req_action_reg == ACT_NONE;
        stamp_one  = sat_add(stamp_cnt_reg, 2'd1);
        stamp_two  = sat_add(stamp_one, 2'd1);
        stamp_next = is_mod ? stamp_two : stamp_one;
        if (is_none)
        begin
            hits_next = 2'd0;
        end
        else if (is_mod)
        begin
            hits_next = hit ? 2'd2 : 2'd1;
        end
        else
        begin
            hits_next = hit ? 2'd1 : 2'd0;
        end
        missed_next  = !is_none && !hit;
        evicted_next = missed_next && !any_empty;
        if (hit)
        begin
            tgt_way = hit_way;
        end
        else if (any_empty)
        begin
            tgt_way = empty_way;
        end
        else
        begin
            tgt_way = lru_way;
        end
        row_wr                = row_rd;
        row_wr[tgt_way].valid = 1'b1;
        row_wr[tgt_way].tag   = req_tag_reg;
        row_wr[tgt_way].stamp = stamp_next;
    end

    // write port: clear sweep or line update
    always_comb
    begin
        wr_en   = cmd.clear_step || (cmd.commit && !is_none);
        wr_addr = cmd.clear_step ? clear_cnt_reg : req_set_reg;
        wr_data = cmd.clear_step ? '0 : row_wr;
    end

    // clear sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_cnt_reg <= '0;
        end
        else if (cmd.clear_step)
        begin
            clear_cnt_reg <= clear_cnt_reg + 1'b1;
        end
    end

    assign status.clear_last = clear_cnt_reg == SET_W'(DEPTH - 1);

    // stamp and running totals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stamp_cnt_reg <= '0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            evict_cnt_reg <= '0;
        end
        else if (cmd.commit && !is_none)
        begin
            stamp_cnt_reg <= stamp_next;
            hit_cnt_reg   <= sat_add(hit_cnt_reg, hits_next);
            miss_cnt_reg  <= sat_add(miss_cnt_reg, {1'b0, missed_next});
            evict_cnt_reg <= sat_add(evict_cnt_reg, {1'b0, evicted_next});
        end
    end

    // per-access result register
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            hits_added_reg <= hits_next;
            missed_reg     <= missed_next;
            evicted_reg    <= evicted_next;
        end
    end

    assign hits_added      = hits_added_reg;
    assign missed          = missed_reg;
    assign evicted         = evicted_reg;
    assign total_hits      = hit_cnt_reg;
    assign total_misses    = miss_cnt_reg;
    assign total_evictions = evict_cnt_reg;

endmodule

// File: rtl/set_assoc_lru_cache_sim.sv
// Set-associative tag cache model with LRU replacement. Each request carries
// an address and an action (load, store, modify, or the ignored fourth code)
// and yields one result with this access's hit count, miss and eviction flags
// and saturating running totals. A request first reads the whole set row
// from the set memory, then compares all ways side by side and writes the
// row back; no new request is taken until the row is written back, and a
// stalled result delays the write-back until the result slot frees. After
// reset the set memory is swept clear, one row per cycle, over 2**MAX_SET_BITS
// rows (256 by default) with in_stall held high; configuration writes are
// taken at any time but should be issued only while no request is in flight.
module set_assoc_lru_cache_sim
    import salc_pkg::*;
#(
    parameter int MAX_SET_BITS = 8,
    parameter int MAX_WAYS     = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [ADDR_W-1:0]     address,
    input  logic [1:0]            action,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            hits_added,
    output logic                  missed,
    output logic                  evicted,
    output logic [CNT_W-1:0]      total_hits,
    output logic [CNT_W-1:0]      total_misses,
    output logic [CNT_W-1:0]      total_evictions,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // configuration registers take a write every cycle
    assign cfg_ready = 1'b1;

    // sequencing
    salc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // lookup, replacement and totals
    salc_dp #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .address         (address),
        .action          (action),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .hits_added      (hits_added),
        .missed          (missed),
        .evicted         (evicted),
        .total_hits      (total_hits),
        .total_misses    (total_misses),
        .total_evictions (total_evictions)
    );

endmodule
